### sv/rrts_pkg.sv
package rrts_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int CMD_W = 2;
  localparam int TGT_W = 2;
  localparam int STS_W = 2;
  localparam int QNT_W = 16;

  localparam logic [QNT_W-1:0] QUANTUM_RESET = 16'd10;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd2;

  localparam logic [TGT_W-1:0] TGT_READY   = 2'd0;
  localparam logic [TGT_W-1:0] TGT_BLOCKED = 2'd1;
  localparam logic [TGT_W-1:0] TGT_RUNNING = 2'd2;
  localparam logic [TGT_W-1:0] TGT_NONE    = 2'd3;

  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_ID = 2'd2;

endpackage

### sv/rrts_qmem.sv
module rrts_qmem #(
  parameter int DEPTH = 16,
  parameter int DW    = 5,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/rrts_sched.sv
module rrts_sched #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
  localparam int IdW = $clog2(MAX_TASKS + 1),
  localparam int AW  = $clog2(MAX_TASKS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [rrts_pkg::QNT_W-1:0] quantum_length,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rrts_pkg::CMD_W-1:0] in_cmd,
  input  logic [IdW-1:0]           in_task_id,
  input  logic [rrts_pkg::TGT_W-1:0] in_target,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IdW-1:0]           out_running_task,
  output logic                     out_running_idle,
  output logic                     out_switched,
  output logic [IdW-1:0]           out_new_task_id,
  output logic [rrts_pkg::QNT_W-1:0] out_quantum_remaining,
  output logic [IdW-1:0]           out_ready_count,
  output logic [rrts_pkg::STS_W-1:0] out_status,
  output logic                     mem_wr_en,
  output logic [AW-1:0]            mem_wr_addr,
  output logic [IdW-1:0]           mem_wr_data,
  output logic [AW-1:0]            mem_rd_addr,
  input  logic [IdW-1:0]           mem_rd_data
);

  import rrts_pkg::*;

  localparam int SW = IdW + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_CREATE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // queue position to memory address, wrapping at the capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [IdW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(MAX_TASKS)) sum = sum - SW'(MAX_TASKS);
    return sum[AW-1:0];
  endfunction

  logic [2:0]       state_r, state_nxt;
  logic [TGT_W-1:0] tgt_r, tgt_nxt;
  logic [IdW-1:0]   tid_r, tid_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [IdW-1:0]   len_r, len_nxt;
  logic [IdW-1:0]   created_r, created_nxt;
  logic [IdW-1:0]   cur_r, cur_nxt;
  logic             idle_r, idle_nxt;
  logic [QNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [IdW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IdW-1:0]   pidx_r, pidx_nxt;
  logic             pend_r, pend_nxt;
  logic             found_r, found_nxt;
  logic [STS_W-1:0] sts_r, sts_nxt;
  logic             sw_r, sw_nxt;
  logic [IdW-1:0]   nid_r, nid_nxt;
  logic             out_valid_r;

  logic [AW-1:0]    head_inc, head_dec;
  logic [QNT_W-1:0] qdec;
  logic [IdW-1:0]   next_id, len_after;
  logic             next_idle, load_out;

  assign head_inc = (head_r == AW'(MAX_TASKS - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? AW'(MAX_TASKS - 1) : head_r - 1'b1;
  assign qdec     = (qcnt_r != '0) ? qcnt_r - 1'b1 : '0;
  assign len_after = len_r - IdW'(found_r);

  always_comb begin
    state_nxt   = state_r;
    tgt_nxt     = tgt_r;
    tid_nxt     = tid_r;
    head_nxt    = head_r;
    len_nxt     = len_r;
    created_nxt = created_r;
    cur_nxt     = cur_r;
    idle_nxt    = idle_r;
    qcnt_nxt    = qcnt_r;
    rd_idx_nxt  = rd_idx_r;
    pidx_nxt    = pidx_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    sts_nxt     = sts_r;
    sw_nxt      = sw_r;
    nid_nxt     = nid_r;
    next_id     = '0;
    next_idle   = 1'b1;
    mem_wr_en   = 1'b0;
    mem_wr_addr = head_r;
    mem_wr_data = mem_rd_data;
    mem_rd_addr = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt = in_target;
          tid_nxt = in_task_id;
          sts_nxt = STS_OK;
          sw_nxt  = 1'b0;
          nid_nxt = '0;
          unique case (in_cmd)
            CMD_TICK: state_nxt = S_TICK;
            CMD_CREATE: begin
              if (created_r >= IdW'(MAX_TASKS) || len_r >= IdW'(MAX_TASKS)) begin
                sts_nxt   = STS_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_CREATE;
              end
            end
            CMD_MOVE: begin
              if (in_task_id == '0 || in_task_id > created_r) begin
                sts_nxt   = STS_BAD_ID;
                state_nxt = S_DONE;
              end else if (in_target == TGT_NONE) begin
                state_nxt = S_DONE;
              end else begin
                rd_idx_nxt = '0;
                pend_nxt   = 1'b0;
                found_nxt  = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_TICK: begin
        // head entry was read during the accept cycle
        if (qdec != '0) begin
          qcnt_nxt = qdec;
        end else begin
          qcnt_nxt = quantum_length;
          if (len_r != '0) begin
            next_id     = mem_rd_data;
            next_idle   = 1'b0;
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_r, len_r);
            mem_wr_data = mem_rd_data;
            head_nxt    = head_inc;
          end
          if (!(next_idle == idle_r && (next_idle || next_id == cur_r))) begin
            sw_nxt   = 1'b1;
            cur_nxt  = next_id;
            idle_nxt = next_idle;
          end
        end
        state_nxt = S_DONE;
      end

      S_CREATE: begin
        nid_nxt     = created_r + 1'b1;
        created_nxt = created_r + 1'b1;
        head_nxt    = head_dec;
        mem_wr_en   = 1'b1;
        mem_wr_addr = head_dec;
        mem_wr_data = created_r + 1'b1;
        len_nxt     = len_r + 1'b1;
        state_nxt   = S_DONE;
      end

      S_SCAN: begin
        // compare the beat read last cycle; once found, close the gap behind it
        if (pend_r) begin
          if (found_r) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_r, pidx_r - 1'b1);
            mem_wr_data = mem_rd_data;
          end else if (mem_rd_data == tid_r) begin
            found_nxt = 1'b1;
          end
        end
        if (rd_idx_r < len_r) begin
          mem_rd_addr = phys(head_r, rd_idx_r);
          pend_nxt    = 1'b1;
          pidx_nxt    = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!pend_r && rd_idx_r >= len_r) begin
          len_nxt = len_after;
          if (tgt_r == TGT_READY && len_after < IdW'(MAX_TASKS)) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = phys(head_r, len_after);
            mem_wr_data = tid_r;
            len_nxt     = len_after + 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      len_r       <= '0;
      created_r   <= '0;
      cur_r       <= '0;
      idle_r      <= 1'b0;
      qcnt_r      <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      len_r     <= len_nxt;
      created_r <= created_nxt;
      cur_r     <= cur_nxt;
      idle_r    <= idle_nxt;
      qcnt_r    <= qcnt_nxt;
      pend_r    <= pend_nxt;
      found_r   <= found_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r    <= tgt_nxt;
    tid_r    <= tid_nxt;
    rd_idx_r <= rd_idx_nxt;
    pidx_r   <= pidx_nxt;
    sts_r    <= sts_nxt;
    sw_r     <= sw_nxt;
    nid_r    <= nid_nxt;
    if (load_out) begin
      out_running_task      <= idle_r ? '0 : cur_r;
      out_running_idle      <= idle_r;
      out_switched          <= sw_r;
      out_new_task_id       <= nid_r;
      out_quantum_remaining <= qcnt_r;
      out_ready_count       <= len_r;
      out_status            <= sts_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/round_robin_task_scheduler_top.sv
// Round-robin task scheduler with a time quantum.
// Input channel (in_valid/in_ready) carries one command beat: timer tick,
// create task, or move task (task id and destination). Output channel
// (out_valid/out_ready) returns one result beat per command: running task,
// idle flag, switch flag, new id, quantum left, ready-queue length, status.
// cfg_wr_en/cfg_wr_data load the quantum length; write it only while idle.
// The ready queue sits in a circular memory with registered reads.
// A tick or create passes through its work state to the done state; a move
// first walks the queue one entry per cycle in the scan state; a rejected or
// ignored command goes straight to the done state. The done state loads the
// result into the output register once that register is free. One command
// is worked at a time and the next is accepted the cycle after a result is
// loaded.
// The output register decouples the sides: the next command is accepted
// while a result still waits, and the scheduler holds its finished result
// only if that register is still occupied when the next one is ready.
// Reset (synchronous, rst_n low) empties the queue, forgets all tasks,
// makes the boot task current and clears the quantum counter, so the first
// tick schedules. Quantum length resets to 10.
module round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
  localparam int IdW = $clog2(MAX_TASKS + 1),
  localparam int AW  = $clog2(MAX_TASKS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [rrts_pkg::QNT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rrts_pkg::CMD_W-1:0] in_cmd,
  input  logic [IdW-1:0]             in_task_id,
  input  logic [rrts_pkg::TGT_W-1:0] in_target,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [IdW-1:0]             out_running_task,
  output logic                       out_running_idle,
  output logic                       out_switched,
  output logic [IdW-1:0]             out_new_task_id,
  output logic [rrts_pkg::QNT_W-1:0] out_quantum_remaining,
  output logic [IdW-1:0]             out_ready_count,
  output logic [rrts_pkg::STS_W-1:0] out_status
);

  import rrts_pkg::*;

  logic [QNT_W-1:0] quantum_length_r;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [IdW-1:0]   mem_wr_data;
  logic [AW-1:0]    mem_rd_addr;
  logic [IdW-1:0]   mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_length_r <= QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      quantum_length_r <= cfg_wr_data;
    end
  end

  rrts_qmem #(
    .DEPTH (MAX_TASKS),
    .DW    (IdW)
  ) u_qmem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rrts_sched #(
    .MAX_TASKS (MAX_TASKS)
  ) u_sched (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .quantum_length        (quantum_length_r),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_task_id            (in_task_id),
    .in_target             (in_target),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_running_task      (out_running_task),
    .out_running_idle      (out_running_idle),
    .out_switched          (out_switched),
    .out_new_task_id       (out_new_task_id),
    .out_quantum_remaining (out_quantum_remaining),
    .out_ready_count       (out_ready_count),
    .out_status            (out_status),
    .mem_wr_en             (mem_wr_en),
    .mem_wr_addr           (mem_wr_addr),
    .mem_wr_data           (mem_wr_data),
    .mem_rd_addr           (mem_rd_addr),
    .mem_rd_data           (mem_rd_data)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rrts_pkg::*;

  localparam int MAX_TASKS = MAX_TASKS_DEF;
  localparam int ID_W = $clog2(MAX_TASKS + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 24;

  typedef enum logic [1:0] {TS_UNUSED, TS_READY, TS_BLOCKED, TS_RUN} task_state_t;

  typedef struct packed {
    logic [ID_W-1:0]  running_task;
    logic             running_idle;
    logic             switched;
    logic [ID_W-1:0]  new_task_id;
    logic [QNT_W-1:0] quantum_remaining;
    logic [ID_W-1:0]  ready_count;
    logic [STS_W-1:0] status;
  } sched_result_t;

  typedef struct {
    bit               is_cfg;
    logic [QNT_W-1:0] cfg_val;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [TGT_W-1:0] tgt;
    int               reps;
    bit               known_ok;
    sched_result_t    known;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [QNT_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [ID_W-1:0]  in_task_id;
  logic [TGT_W-1:0] in_target;
  logic             out_valid;
  logic             out_ready;
  logic [ID_W-1:0]  out_running_task;
  logic             out_running_idle;
  logic             out_switched;
  logic [ID_W-1:0]  out_new_task_id;
  logic [QNT_W-1:0] out_quantum_remaining;
  logic [ID_W-1:0]  out_ready_count;
  logic [STS_W-1:0] out_status;

  round_robin_task_scheduler_top #(.MAX_TASKS(MAX_TASKS)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_task_id            (in_task_id),
    .in_target             (in_target),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_running_task      (out_running_task),
    .out_running_idle      (out_running_idle),
    .out_switched          (out_switched),
    .out_new_task_id       (out_new_task_id),
    .out_quantum_remaining (out_quantum_remaining),
    .out_ready_count       (out_ready_count),
    .out_status            (out_status)
  );

  // scheduler shadow state
  logic [ID_W-1:0]  run_queue [MAX_TASKS];
  int               queue_len;
  task_state_t      tstate [1:MAX_TASKS];
  int               created;
  logic [ID_W-1:0]  cur_task;
  bit               cur_idle;
  logic [QNT_W-1:0] qcount;
  logic [QNT_W-1:0] qlength;

  sched_result_t pending_results [$];
  stim_row_t     directed [$];
  int  errors;
  int  burst_left;
  bit  hold_req;
  int  n_tick, n_create, n_move, n_switch, n_full, n_bad_id;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void reset_model();
    queue_len = 0;
    created = 0;
    cur_task = '0;
    cur_idle = 1'b0;
    qcount = '0;
    qlength = QUANTUM_RESET;
    for (int i = 1; i <= MAX_TASKS; i++) tstate[i] = TS_UNUSED;
  endfunction

  function automatic sched_result_t schedule_step(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                                  logic [TGT_W-1:0] t);
    sched_result_t r;
    logic [ID_W-1:0] nxt;
    bit nxt_idle;
    bit found;
    r = '0;
    r.status = STS_OK;
    if (c == CMD_TICK) begin
      n_tick++;
      if (qcount > 0) qcount--;
      if (qcount == 0) begin
        nxt = '0;
        nxt_idle = 1'b1;
        if (queue_len > 0) begin
          // rotate the head to the tail
          nxt = run_queue[0];
          for (int j = 0; j + 1 < queue_len; j++) run_queue[j] = run_queue[j+1];
          run_queue[queue_len-1] = nxt;
          nxt_idle = 1'b0;
        end
        qcount = qlength;
        if (!(nxt_idle == cur_idle && (nxt_idle || nxt == cur_task))) begin
          if (!cur_idle && cur_task >= 1 && tstate[cur_task] == TS_RUN)
            tstate[cur_task] = TS_READY;
          cur_idle = nxt_idle;
          cur_task = nxt;
          if (!nxt_idle) tstate[nxt] = TS_RUN;
          r.switched = 1'b1;
          n_switch++;
        end
      end
    end else if (c == CMD_CREATE) begin
      n_create++;
      if (created >= MAX_TASKS || queue_len >= MAX_TASKS) begin
        r.status = STS_FULL;
        n_full++;
      end else begin
        created++;
        r.new_task_id = ID_W'(created);
        for (int j = queue_len; j > 0; j--) run_queue[j] = run_queue[j-1];
        run_queue[0] = ID_W'(created);
        queue_len++;
        tstate[created] = TS_READY;
      end
    end else if (c == CMD_MOVE) begin
      n_move++;
      if (id < 1 || id > created) begin
        r.status = STS_BAD_ID;
        n_bad_id++;
      end else if (t != TGT_NONE) begin
        found = 1'b0;
        for (int i = 0; i < queue_len; i++) begin
          if (!found && run_queue[i] == id) found = 1'b1;
          if (found && i + 1 < queue_len) run_queue[i] = run_queue[i+1];
        end
        if (found) queue_len--;
        if (t == TGT_READY) begin
          if (queue_len < MAX_TASKS) begin
            run_queue[queue_len] = id;
            queue_len++;
          end
          tstate[id] = TS_READY;
        end else if (t == TGT_BLOCKED) begin
          tstate[id] = TS_BLOCKED;
        end else begin
          tstate[id] = TS_RUN;
        end
      end
    end
    r.running_task = cur_idle ? '0 : cur_task;
    r.running_idle = cur_idle;
    r.quantum_remaining = qcount;
    r.ready_count = ID_W'(queue_len);
    return r;
  endfunction

  function automatic stim_row_t plan_cmd(logic [CMD_W-1:0] c, int id, logic [TGT_W-1:0] t,
                                         int reps = 1);
    stim_row_t row;
    row = '{default: '0};
    row.cmd = c;
    row.id = ID_W'(id);
    row.tgt = t;
    row.reps = reps;
    return row;
  endfunction

  function automatic stim_row_t plan_quantum(int v);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_val = QNT_W'(v);
    return row;
  endfunction

  function automatic stim_row_t with_known(stim_row_t row, int run, bit idle, bit sw, int nid,
                                           int q, int rc, logic [STS_W-1:0] st);
    row.known_ok = 1'b1;
    row.known = '{ID_W'(run), idle, sw, ID_W'(nid), QNT_W'(q), ID_W'(rc), st};
    return row;
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                           input logic [TGT_W-1:0] t, input bit known_ok,
                           input sched_result_t known);
    sched_result_t r;
    int gap;
    in_valid <= 1'b1;
    in_cmd <= c;
    in_task_id <= id;
    in_target <= t;
    do @(posedge clk); while (!in_ready);
    r = schedule_step(c, id, t);
    pending_results.push_back(known_ok ? known : r);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic finish_inflight();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
  endtask

  task automatic load_quantum(input logic [QNT_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    qlength = v;
  endtask

  task automatic check_field(input string fname, input int exp, input int got);
    if (exp != got) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    sched_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got running %0d",
                 $time, out_running_task);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        check_field("running_task", exp.running_task, out_running_task);
        check_field("running_idle", exp.running_idle, out_running_idle);
        check_field("switched", exp.switched, out_switched);
        check_field("new_task_id", exp.new_task_id, out_new_task_id);
        check_field("quantum_remaining", exp.quantum_remaining, out_quantum_remaining);
        check_field("ready_count", exp.ready_count, out_ready_count);
        check_field("status", exp.status, out_status);
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    int seg;
    int mode;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        seg = $urandom_range(20, 80);
        repeat (seg) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [QNT_W-1:0] quanta [6];
    stim_row_t row;
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0] id;
    logic [TGT_W-1:0] t;
    int pick;
    int useful;

    quanta = '{16'd3, 16'd0, 16'd7, 16'd1, 16'd2, 16'hFFFF};
    errors = 0;
    burst_left = 0;
    hold_req = 1'b0;
    {n_tick, n_create, n_move, n_switch, n_full, n_bad_id} = '0;
    reset_model();
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_cmd <= CMD_TICK;
    in_task_id <= '0;
    in_target <= TGT_READY;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: boot tick to idle, bad ids, creates, preemption, moves of the
    // running task, ignored items, then fill the task table
    directed.push_back(plan_quantum(0));
    directed.push_back(with_known(plan_cmd(CMD_TICK, 0, TGT_READY),
                                  0, 1, 1, 0, 0, 0, STS_OK));
    directed.push_back(with_known(plan_cmd(CMD_MOVE, 0, TGT_READY),
                                  0, 1, 0, 0, 0, 0, STS_BAD_ID));
    directed.push_back(with_known(plan_cmd(CMD_MOVE, 1, TGT_BLOCKED),
                                  0, 1, 0, 0, 0, 0, STS_BAD_ID));
    directed.push_back(with_known(plan_cmd(CMD_CREATE, 0, TGT_READY),
                                  0, 1, 0, 1, 0, 1, STS_OK));
    directed.push_back(with_known(plan_cmd(CMD_TICK, 0, TGT_READY),
                                  1, 0, 1, 0, 0, 1, STS_OK));
    directed.push_back(plan_cmd(CMD_CREATE, 0, TGT_READY, 2));
    directed.push_back(plan_cmd(CMD_TICK, 0, TGT_READY));
    directed.push_back(plan_cmd(CMD_MOVE, 3, TGT_BLOCKED));
    directed.push_back(plan_cmd(CMD_TICK, 0, TGT_READY));
    directed.push_back(plan_cmd(CMD_MOVE, 1, TGT_RUNNING));
    directed.push_back(plan_cmd(CMD_MOVE, 2, TGT_NONE));
    directed.push_back(plan_cmd(CMD_UNUSED, 31, TGT_NONE));
    directed.push_back(plan_cmd(CMD_MOVE, 3, TGT_READY));
    directed.push_back(plan_quantum(1));
    directed.push_back(plan_cmd(CMD_TICK, 0, TGT_READY, 2));
    directed.push_back(plan_cmd(CMD_CREATE, 0, TGT_READY, 13));
    directed.push_back(with_known(plan_cmd(CMD_CREATE, 0, TGT_READY),
                                  3, 0, 0, 0, 1, 15, STS_FULL));
    directed.push_back(plan_cmd(CMD_MOVE, 31, TGT_RUNNING));

    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_cfg) begin
        finish_inflight();
        load_quantum(row.cfg_val);
      end else begin
        repeat (row.reps) send_beat(row.cmd, row.id, row.tgt, row.known_ok, row.known);
      end
    end

    // random phases, one quantum length each; the largest goes last so the
    // counter it loads cannot starve later phases
    foreach (quanta[ph]) begin
      finish_inflight();
      load_quantum(quanta[ph]);
      if (ph == 1) hold_req = 1'b1;
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        c = CMD_MOVE;
        id = ID_W'($urandom_range(1, MAX_TASKS));
        t = TGT_W'($urandom_range(TGT_READY, TGT_RUNNING));
        if (pick < 40) begin
          c = CMD_TICK;
          id = ID_W'($urandom);
          t = TGT_W'($urandom);
        end else if (pick >= 75 && pick < 82) begin
          c = CMD_CREATE;
          id = ID_W'($urandom);
          t = TGT_W'($urandom);
        end else if (pick >= 82 && pick < 88) begin
          id = ($urandom_range(0, 1) == 1) ?
               ID_W'($urandom_range(MAX_TASKS + 1, 2**ID_W - 1)) : '0;
          t = TGT_W'($urandom);
        end else if (pick >= 88 && pick < 94) begin
          t = TGT_NONE;
        end else if (pick >= 94) begin
          c = CMD_UNUSED;
          id = ID_W'($urandom);
          t = TGT_W'($urandom);
        end
        send_beat(c, id, t, 1'b0, '0);
        if (!(c == CMD_UNUSED || (c == CMD_MOVE && t == TGT_NONE && id >= 1 &&
              id <= created)))
          useful++;
      end
    end

    finish_inflight();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d ticks, %0d creates, %0d moves and %0d task switches",
             n_tick, n_create, n_move, n_switch);
    $display("over quantum lengths 0 to 65535; %0d creates refused, %0d unknown ids",
             n_full, n_bad_id);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
